// ----- sv/pmrs_pkg.sv -----
`default_nettype none
package pmrs_pkg;

  // field widths fixed by the interface
  localparam int ID_W     = 16;
  localparam int RATE_W   = 16;
  localparam int PERIOD_W = 13;

  // period = DIVIDEND / rate, computed one quotient bit per cycle
  localparam int               DIV_STEPS = 14;
  localparam logic [13:0]      DIVIDEND  = 14'd10000;

  localparam logic [ID_W-1:0]  LIMIT_RESET = 16'd256;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_PORT = 2'd1;
  localparam logic [1:0] ST_BAD_ID   = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // function codes
  localparam logic FN_SET  = 1'b0;
  localparam logic FN_TICK = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [2:0]               port;
    logic [ID_W-1:0]          msg_id;
    logic signed [RATE_W-1:0] rate_centihz;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            due;
    logic [ID_W-1:0] due_msg_id;
    logic            last;
  } out_word_t;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [ID_W-1:0]     msg_id;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] counter;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- sv/periodic_message_rate_scheduler_core.sv -----
`default_nettype none
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   in_word  (func, port, msg_id, rate_centihz)
// out_      output     out_valid / out_stall out_word (status, due, due_msg_id, last)
// cfg_      input      cfg_we                cfg_wdata (msg_id_limit)
//
// one item at a time; in_stall is high from acceptance until its final word is registered.
// set: the quotient is built one bit per cycle when the rate is above one, then entries are
//   scanned and shifted one at a time through the entry ram (one write, one read port).
// tick: each entry walked is a ram read, then an update; out_stall can hold the walk.
// reset clears the per-port fill counts and msg_id_limit to 256; no clearing pass.
// out_stall delays the walk while a due word waits for the output register, and the
//   final word of any item the same way.
module periodic_message_rate_scheduler_core
  import pmrs_pkg::*;
#(
  parameter int PORTS            = 4,
  parameter int ENTRIES_PER_PORT = 32,
  parameter int MAX_DUE_PER_TICK = 20
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word,
  input  wire logic      cfg_we,
  input  wire logic [ID_W-1:0] cfg_wdata
);

  localparam int DEPTH = PORTS * ENTRIES_PER_PORT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (ENTRIES_PER_PORT > 1) ? $clog2(ENTRIES_PER_PORT) : 1;
  localparam int CW    = $clog2(ENTRIES_PER_PORT + 1);
  localparam int PW    = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int EW    = $clog2(MAX_DUE_PER_TICK + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DIV   = 11'b000_0000_0010,
    S_SRD   = 11'b000_0000_0100,
    S_SCMP  = 11'b000_0000_1000,
    S_MRD   = 11'b000_0001_0000,
    S_MWR   = 11'b000_0010_0000,
    S_IRD   = 11'b000_0100_0000,
    S_IWR   = 11'b000_1000_0000,
    S_TRD   = 11'b001_0000_0000,
    S_TPROC = 11'b010_0000_0000,
    S_RESP  = 11'b100_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ID_W-1:0]     limit_r, limit_nxt;
  logic [CW-1:0]       cnt_r [PORTS];
  logic [CW-1:0]       cnt_nxt [PORTS];
  logic [2:0]          port_r, port_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [14:0]         divisor_r, divisor_nxt;
  logic [14:0]         rem_r, rem_nxt;
  logic [13:0]         quo_r, quo_nxt;
  logic [3:0]          step_r, step_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [EW-1:0]       emit_r, emit_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  // ram ports
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_ent;

  pmrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  // shared address and arithmetic terms
  logic [PW-1:0]       port_idx;
  logic [AW-1:0]       base;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       idx_dec, idx_inc;
  logic [15:0]         rem_sh;
  logic                div_ge;
  logic [15:0]         rem_sub;
  logic [13:0]         quo_fin;
  logic [PERIOD_W-1:0] ctr_inc;
  logic                tick_due;
  logic                out_free;
  logic                accept;
  logic                in_port_ok;
  logic [14:0]         in_rate_mag;

  assign port_idx = port_r[PW-1:0];
  assign base     = AW'(port_idx * ENTRIES_PER_PORT);
  assign fill     = cnt_r[port_idx];
  assign idx_dec  = idx_r - 1'b1;
  assign idx_inc  = idx_r + 1'b1;

  // restoring divider step
  assign rem_sh  = {rem_r, quo_r[13]};
  assign div_ge  = (rem_sh >= {1'b0, divisor_r});
  assign rem_sub = rem_sh - {1'b0, divisor_r};
  assign quo_fin = {quo_r[12:0], div_ge};

  // tick counter update
  assign ctr_inc  = rd_ent.counter + 1'b1;
  assign tick_due = (ctr_inc >= rd_ent.period);

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign in_port_ok  = (32'(in_word.port) < PORTS);
  assign in_rate_mag = in_word.rate_centihz[14:0];

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    cnt_nxt       = cnt_r;
    port_nxt      = port_r;
    id_nxt        = id_r;
    divisor_nxt   = divisor_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    period_nxt    = period_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    emit_nxt      = emit_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = base + AW'(pos_r[SW-1:0]);
    ram_raddr     = base + AW'(pos_r[SW-1:0]);
    ram_wdata     = rd_ent;

    // output register drains when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // configuration write
    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          port_nxt    = in_word.port;
          id_nxt      = in_word.msg_id;
          divisor_nxt = in_rate_mag;
          rem_nxt     = '0;
          quo_nxt     = DIVIDEND;
          step_nxt    = '0;
          pos_nxt     = '0;
          idx_nxt     = '0;
          emit_nxt    = '0;
          pend_v_nxt  = 1'b0;
          status_nxt  = ST_OK;
          if (!in_port_ok) begin
            status_nxt = ST_BAD_PORT;
            state_nxt  = S_RESP;
          end else if (in_word.func == FN_TICK) begin
            state_nxt = S_TRD;
          end else if (in_word.msg_id >= limit_r) begin
            status_nxt = ST_BAD_ID;
            state_nxt  = S_RESP;
          end else if (!in_word.rate_centihz[15] && in_rate_mag > 15'd1) begin
            state_nxt = S_DIV;
          end else begin
            // zero removes, one or negative gives the shortest period
            period_nxt = (in_rate_mag == 15'd0 && !in_word.rate_centihz[15]) ?
                         PERIOD_W'(0) : PERIOD_W'(1);
            state_nxt  = S_SRD;
          end
        end
      end

      // one quotient bit per cycle
      S_DIV: begin
        rem_nxt  = div_ge ? rem_sub[14:0] : rem_sh[14:0];
        quo_nxt  = quo_fin;
        step_nxt = step_r + 1'b1;
        if (step_r == 4'(DIV_STEPS - 1)) begin
          period_nxt = (quo_fin == '0) ? PERIOD_W'(1) : quo_fin[PERIOD_W-1:0];
          state_nxt  = S_SRD;
        end
      end

      // scan for the first entry with id not below the request
      S_SRD: begin
        if (pos_r == fill) begin
          idx_nxt = fill;
          if (period_r == '0) begin
            state_nxt = S_RESP;
          end else if (fill == CW'(ENTRIES_PER_PORT)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_IRD;
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_SCMP;
        end
      end

      S_SCMP: begin
        idx_nxt = pos_r;
        if (rd_ent.msg_id < id_r) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_SRD;
        end else if (rd_ent.msg_id == id_r) begin
          if (period_r != '0) begin
            // new period, counter kept
            ram_we           = 1'b1;
            ram_wdata.period = period_r;
            state_nxt        = S_RESP;
          end else begin
            state_nxt = S_MRD;
          end
        end else if (period_r == '0) begin
          state_nxt = S_RESP;
        end else if (fill == CW'(ENTRIES_PER_PORT)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt   = fill;
          state_nxt = S_IRD;
        end
      end

      // removal: pull later entries down by one
      S_MRD: begin
        if (idx_inc == fill) begin
          cnt_nxt[port_idx] = fill - 1'b1;
          state_nxt         = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = base + AW'(idx_inc[SW-1:0]);
          state_nxt = S_MWR;
        end
      end

      S_MWR: begin
        ram_we    = 1'b1;
        ram_waddr = base + AW'(idx_r[SW-1:0]);
        idx_nxt   = idx_inc;
        state_nxt = S_MRD;
      end

      // insertion: push later entries up by one, then write the new one
      S_IRD: begin
        if (idx_r == pos_r) begin
          ram_we            = 1'b1;
          ram_wdata.msg_id  = id_r;
          ram_wdata.period  = period_r;
          ram_wdata.counter = '0;
          cnt_nxt[port_idx] = fill + 1'b1;
          state_nxt         = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = base + AW'(idx_dec[SW-1:0]);
          state_nxt = S_IWR;
        end
      end

      S_IWR: begin
        ram_we    = 1'b1;
        ram_waddr = base + AW'(idx_r[SW-1:0]);
        idx_nxt   = idx_dec;
        state_nxt = S_IRD;
      end

      // tick walk: read next entry
      S_TRD: begin
        if (idx_r == fill) begin
          state_nxt = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = base + AW'(idx_r[SW-1:0]);
          state_nxt = S_TPROC;
        end
      end

      // tick walk: update counter, hold one due word back to mark the last
      S_TPROC: begin
        ram_waddr = base + AW'(idx_r[SW-1:0]);
        if (!tick_due) begin
          ram_we            = 1'b1;
          ram_wdata.counter = ctr_inc;
          idx_nxt           = idx_inc;
          state_nxt         = S_TRD;
        end else if (emit_r == EW'(MAX_DUE_PER_TICK)) begin
          ram_we            = 1'b1;
          ram_wdata.counter = '0;
          state_nxt         = S_RESP;
        end else if (!pend_v_r || out_free) begin
          ram_we            = 1'b1;
          ram_wdata.counter = '0;
          if (pend_v_r) begin
            out_valid_nxt           = 1'b1;
            out_word_nxt.status     = ST_OK;
            out_word_nxt.due        = 1'b1;
            out_word_nxt.due_msg_id = pend_id_r;
            out_word_nxt.last       = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = rd_ent.msg_id;
          emit_nxt    = emit_r + 1'b1;
          idx_nxt     = idx_inc;
          state_nxt   = S_TRD;
        end
      end

      // final word of the item
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.status     = status_r;
          out_word_nxt.due        = pend_v_r;
          out_word_nxt.due_msg_id = pend_v_r ? pend_id_r : '0;
          out_word_nxt.last       = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      for (int p = 0; p < PORTS; p++) begin
        cnt_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    port_r     <= port_nxt;
    id_r       <= id_nxt;
    divisor_r  <= divisor_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    period_r   <= period_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    emit_r     <= emit_nxt;
    pend_v_r   <= pend_v_nxt;
    pend_id_r  <= pend_id_nxt;
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ----- sv/pmrs_ram.sv -----
`default_nettype none
module pmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
